@@ rtl/hbpcm_pkg.sv @@
`timescale 1ns / 1ps

package hbpcm_pkg;

  // Stream and sample widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RunW    = 3;
  localparam int unsigned CfgIdxW = 2;

  // Header scan: a run of four CR/LF bytes closes the header.
  localparam logic [RunW-1:0]  HdrEndRun = RunW'(4);
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;

  // Offset that turns an unsigned 8-bit sample into a signed one.
  localparam logic [ByteW-1:0] MidOffset = 8'd128;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSixteenBit   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBigEndian    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTwoChannels  = 2'd2;

  // Item kinds.
  localparam logic KindByte  = 1'b0;
  localparam logic KindStart = 1'b1;

endpackage

@@ rtl/http_body_pcm_sample_unpacker.sv @@
`timescale 1ns / 1ps

// Unpacks a byte stream that carries an HTTP response followed by raw PCM into
// signed 16-bit left/right sample pairs. A start item clears the header scan and all
// partial samples; header bytes are dropped until four CR/LF bytes in a row are
// seen. Each accepted item is held in an input register. While it is there the
// header scan, byte pairing and channel pairing run on it, and a finished pair is
// loaded into the output register when the byte that completes it leaves the input
// register. While the receiver does not stall, one item is accepted in
// every clock cycle. While the receiver stalls a pair in the output register, the
// item in the input register waits, so the block takes at most one more item and
// then stalls its input until the pair is taken.
module http_body_pcm_sample_unpacker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input item channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [hbpcm_pkg::ByteW-1:0]         data_byte_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hbpcm_pkg::SampleW-1:0] left_sample_o,
  output logic signed [hbpcm_pkg::SampleW-1:0] right_sample_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hbpcm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic                                cfg_data_i
);

  localparam int unsigned ByteW   = hbpcm_pkg::ByteW;
  localparam int unsigned SampleW = hbpcm_pkg::SampleW;
  localparam int unsigned RunW    = hbpcm_pkg::RunW;

  // Configuration registers.
  logic sixteen_bit_q, big_endian_q, two_channels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sixteen_bit_q  <= 1'b1;
      big_endian_q   <= 1'b0;
      two_channels_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hbpcm_pkg::CfgSixteenBit:  sixteen_bit_q  <= cfg_data_i;
        hbpcm_pkg::CfgBigEndian:   big_endian_q   <= cfg_data_i;
        hbpcm_pkg::CfgTwoChannels: two_channels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic             in_valid_q;
  logic             kind_q;
  logic [ByteW-1:0] byte_q;
  logic             advance;
  logic             in_accept;

  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      byte_q <= data_byte_i;
    end
  end

  // Stream state.
  logic [RunW-1:0]    run_q, run_d;
  logic [ByteW-1:0]   first_q, first_d;
  logic               byte_phase_q, byte_phase_d;
  logic [SampleW-1:0] left_hold_q, left_hold_d;
  logic               chan_phase_q, chan_phase_d;

  // Per-item logic: header scan, byte pairing and channel pairing.
  logic [SampleW-1:0] sample;
  logic [ByteW-1:0]   offset_byte;
  logic               have_sample;
  logic               emit;
  logic [SampleW-1:0] res_left, res_right;

  always_comb begin
    run_d        = run_q;
    first_d      = first_q;
    byte_phase_d = byte_phase_q;
    left_hold_d  = left_hold_q;
    chan_phase_d = chan_phase_q;
    emit         = 1'b0;
    have_sample  = 1'b0;
    offset_byte  = byte_q - hbpcm_pkg::MidOffset;

    // Sample assembled from the current byte, used only in the body.
    if (!sixteen_bit_q) begin
      sample = {offset_byte, {ByteW{1'b0}}};
    end else if (big_endian_q) begin
      sample = {first_q, byte_q};
    end else begin
      sample = {byte_q, first_q};
    end

    res_left  = sample;
    res_right = sample;

    if (kind_q == hbpcm_pkg::KindStart) begin
      run_d        = '0;
      first_d      = '0;
      byte_phase_d = 1'b0;
      left_hold_d  = '0;
      chan_phase_d = 1'b0;
    end else if (run_q < hbpcm_pkg::HdrEndRun) begin
      if (byte_q == hbpcm_pkg::ChCr || byte_q == hbpcm_pkg::ChLf) begin
        run_d = run_q + RunW'(1);
      end else begin
        run_d = '0;
      end
    end else if (sixteen_bit_q && !byte_phase_q) begin
      first_d      = byte_q;
      byte_phase_d = 1'b1;
    end else begin
      byte_phase_d = 1'b0;
      have_sample  = 1'b1;
    end

    // Channel pairing once a full sample is in hand.
    if (have_sample) begin
      if (two_channels_q && !chan_phase_q) begin
        left_hold_d  = sample;
        chan_phase_d = 1'b1;
      end else begin
        chan_phase_d = 1'b0;
        emit         = 1'b1;
        if (two_channels_q) begin
          res_left = left_hold_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      first_q      <= '0;
      byte_phase_q <= 1'b0;
      left_hold_q  <= '0;
      chan_phase_q <= 1'b0;
    end else if (advance) begin
      run_q        <= run_d;
      first_q      <= first_d;
      byte_phase_q <= byte_phase_d;
      left_hold_q  <= left_hold_d;
      chan_phase_q <= chan_phase_d;
    end
  end

  // Output register.
  logic               out_valid_q;
  logic [SampleW-1:0] left_q, right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      left_q  <= res_left;
      right_q <= res_right;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = $signed(left_q);
  assign right_sample_o = $signed(right_q);

endmodule

@@ rtl/hbpcm_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks for the sample unpacker.
module hbpcm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [hbpcm_pkg::SampleW-1:0] left_sample_o,
  input logic signed [hbpcm_pkg::SampleW-1:0] right_sample_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(left_sample_o) && $stable(right_sample_o))
    else $error("stalled result changed");

  // The input stalls only when a finished result is held back by the output side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could move");

  // No result is shown right after reset is released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid coming out of reset");

endmodule

bind http_body_pcm_sample_unpacker hbpcm_checker u_hbpcm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .left_sample_o  (left_sample_o),
  .right_sample_o (right_sample_o)
);

@@ verif/http_body_pcm_sample_unpacker_tb.sv @@
`timescale 1ns / 1ps

module http_body_pcm_sample_unpacker_tb;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 6;
  localparam int HoldOffCycles = 300;

  typedef struct {
    logic signed [hbpcm_pkg::SampleW-1:0] left_s;
    logic signed [hbpcm_pkg::SampleW-1:0] right_s;
  } sample_pair_t;

  // Clock and block ports.
  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic kind_i;
  logic [hbpcm_pkg::ByteW-1:0] data_byte_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [hbpcm_pkg::SampleW-1:0] left_sample_o;
  logic signed [hbpcm_pkg::SampleW-1:0] right_sample_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [hbpcm_pkg::CfgIdxW-1:0] cfg_index_i;
  logic cfg_data_i;

  // Idle rates of both sides, in percent of cycles.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Hold-off requests from the tests and those the receiver has started.
  int holdoff_asked = 0;
  int holdoff_taken = 0;
  int holdoff_left  = 0;
  int quiet_cycles  = 0;
  int n_errors      = 0;

  // Pairs predicted for the output, oldest first.
  sample_pair_t pending_pairs[$];
  sample_pair_t seen_pair;

  // Predictor copy of the registers and the unpacking state.
  logic             mode_16bit;
  logic             mode_big_endian;
  logic             mode_stereo;
  logic [hbpcm_pkg::RunW-1:0]    crlf_run;
  logic [hbpcm_pkg::ByteW-1:0]   first_byte;
  logic             first_byte_valid;
  logic [hbpcm_pkg::SampleW-1:0] left_pending;
  logic             left_valid;

  http_body_pcm_sample_unpacker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Clears the stream state, as a start item does.
  task automatic clear_stream_state();
    crlf_run = '0;
    first_byte = '0;
    first_byte_valid = 1'b0;
    left_pending = '0;
    left_valid = 1'b0;
  endtask

  // Advances the predictor by one accepted item and queues any finished pair.
  task automatic predict_byte(input logic kind, input logic [hbpcm_pkg::ByteW-1:0] b);
    logic [hbpcm_pkg::SampleW-1:0] smp;
    logic [hbpcm_pkg::ByteW-1:0] centered;
    logic have_sample;
    sample_pair_t pair;
    have_sample = 1'b0;
    if (kind == hbpcm_pkg::KindStart) begin
      clear_stream_state();
    end else if (crlf_run < hbpcm_pkg::HdrEndRun) begin
      if (b == hbpcm_pkg::ChCr || b == hbpcm_pkg::ChLf) begin
        crlf_run = crlf_run + hbpcm_pkg::RunW'(1);
      end else begin
        crlf_run = '0;
      end
    end else if (mode_16bit) begin
      if (!first_byte_valid) begin
        first_byte = b;
        first_byte_valid = 1'b1;
      end else begin
        first_byte_valid = 1'b0;
        smp = mode_big_endian ? {first_byte, b} : {b, first_byte};
        have_sample = 1'b1;
      end
    end else begin
      // A pending first byte is dropped when the mode is 8-bit.
      first_byte_valid = 1'b0;
      centered = b - hbpcm_pkg::MidOffset;
      smp = {centered, 8'h00};
      have_sample = 1'b1;
    end
    if (have_sample) begin
      if (mode_stereo && !left_valid) begin
        left_pending = smp;
        left_valid = 1'b1;
      end else begin
        pair.left_s = mode_stereo ? left_pending : smp;
        pair.right_s = smp;
        left_valid = 1'b0;
        pending_pairs.push_back(pair);
      end
    end
  endtask

  // Offers one item, idling first at the current rate, and waits for acceptance.
  task automatic send_item(input logic kind, input logic [hbpcm_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(kind, b);
  endtask

  // Waits until every predicted pair has arrived and the pipeline is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers back to back once the block is idle.
  task automatic set_mode(input logic s16, input logic be, input logic st);
    logic [hbpcm_pkg::CfgIdxW-1:0] idx[3];
    logic val[3];
    idx = '{hbpcm_pkg::CfgSixteenBit, hbpcm_pkg::CfgBigEndian, hbpcm_pkg::CfgTwoChannels};
    val = '{s16, be, st};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    mode_16bit = s16;
    mode_big_endian = be;
    mode_stereo = st;
  endtask

  // Header scan with a broken CR/LF run, then one stereo frame of extreme samples.
  task automatic test_header_scan();
    send_item(hbpcm_pkg::KindStart, 8'h00);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChCr);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChLf);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChCr);
    send_item(hbpcm_pkg::KindByte, 8'h41);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChLf);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChCr);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChLf);
    send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChCr);
    send_item(hbpcm_pkg::KindByte, 8'h00);
    send_item(hbpcm_pkg::KindByte, 8'h80);
    send_item(hbpcm_pkg::KindByte, 8'hFF);
    send_item(hbpcm_pkg::KindByte, 8'h7F);
  endtask

  // Mode changes that drop a pending first byte and a pending left sample.
  task automatic test_mode_switch();
    set_mode(1'b1, 1'b1, 1'b1);
    send_item(hbpcm_pkg::KindByte, 8'h12);
    set_mode(1'b0, 1'b0, 1'b1);
    send_item(hbpcm_pkg::KindByte, 8'h00);
    set_mode(1'b0, 1'b0, 1'b0);
    send_item(hbpcm_pkg::KindByte, 8'hFF);
    set_mode(1'b1, 1'b1, 1'b0);
    send_item(hbpcm_pkg::KindByte, 8'h80);
    send_item(hbpcm_pkg::KindByte, 8'h01);
    // A start item ignores its byte; the next byte is header again.
    send_item(hbpcm_pkg::KindStart, 8'hFF);
    send_item(hbpcm_pkg::KindByte, 8'h00);
  endtask

  // The receiver holds off while the sender keeps offering bytes.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(1'b0, 1'b0, 1'b0);
    send_item(hbpcm_pkg::KindStart, 8'h00);
    repeat (4) send_item(hbpcm_pkg::KindByte, hbpcm_pkg::ChLf);
    holdoff_asked++;
    repeat (60) send_item(hbpcm_pkg::KindByte, 8'($urandom));
    settle();
  endtask

  // Mostly well-formed streams with random content, some noise and broken ones.
  task automatic test_random_streams(input int body_target, input int snd_pct,
                                     input int rcv_pct);
    int body_sent;
    int hdr_len;
    int body_len;
    int pick;
    logic [hbpcm_pkg::ByteW-1:0] b;
    body_sent = 0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    while (body_sent < body_target) begin
      if ($urandom_range(99) < 30) begin
        set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 90) begin
        send_item(hbpcm_pkg::KindStart, 8'($urandom));
        hdr_len = $urandom_range(12);
        // Header text with random CR and LF bytes; a run of four of them can close it early.
        for (int i = 0; i < hdr_len; i++) begin
          pick = $urandom_range(3);
          b = (pick == 0) ? hbpcm_pkg::ChCr : (pick == 1) ? hbpcm_pkg::ChLf : 8'($urandom);
          send_item(hbpcm_pkg::KindByte, b);
        end
        repeat (4) begin
          send_item(hbpcm_pkg::KindByte,
                    $urandom_range(1) ? hbpcm_pkg::ChCr : hbpcm_pkg::ChLf);
        end
      end
      body_len = ($urandom_range(19) == 0) ? 120 : $urandom_range(1, 40);
      for (int i = 0; i < body_len; i++) begin
        if ($urandom_range(199) == 0) begin
          send_item(hbpcm_pkg::KindStart, 8'($urandom));
        end else begin
          send_item(hbpcm_pkg::KindByte, 8'($urandom));
          body_sent++;
        end
      end
    end
  endtask

  // Receiver stall, with a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (holdoff_taken != holdoff_asked) begin
      holdoff_taken <= holdoff_asked;
      holdoff_left <= HoldOffCycles;
      out_stall_i <= 1'b1;
    end else if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every accepted pair with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: left_sample %0d right_sample %0d",
               left_sample_o, right_sample_o);
        n_errors++;
      end else begin
        seen_pair = pending_pairs.pop_front();
        if (left_sample_o !== seen_pair.left_s) begin
          $error("left_sample: expected %0d, got %0d", seen_pair.left_s, left_sample_o);
          n_errors++;
        end
        if (right_sample_o !== seen_pair.right_s) begin
          $error("right_sample: expected %0d, got %0d", seen_pair.right_s, right_sample_o);
          n_errors++;
        end
      end
    end
  end

  // Ends the run when no handshake of any channel completes for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i <= hbpcm_pkg::KindByte;
    data_byte_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= hbpcm_pkg::CfgSixteenBit;
    cfg_data_i <= 1'b0;
    mode_16bit = 1'b1;
    mode_big_endian = 1'b0;
    mode_stereo = 1'b1;
    clear_stream_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 77;
    test_header_scan();
    test_mode_switch();
    test_output_backpressure();
    test_random_streams(420, 22, 77);
    test_random_streams(420, 77, 22);
    test_random_streams(420, 0, 0);
    settle();

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hbpcm_pkg.sv
rtl/http_body_pcm_sample_unpacker.sv
rtl/hbpcm_checker.sv
verif/http_body_pcm_sample_unpacker_tb.sv
